// File: sv/dmm_pkg.sv
`default_nettype none

package dmm_pkg;

    localparam int DIM_DEF = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 4;

    typedef enum logic [1:0] {
        OP_WR_A   = 2'd0,
        OP_WR_B   = 2'd1,
        OP_ROW    = 2'd2,
        OP_UNUSED = 2'd3
    } dmm_op_t;

    // one element of the A row on its way down the cell chain
    typedef struct packed {
        logic              vld;
        logic              first;
        logic              last;
        logic [DATA_W-1:0] a;
    } dmm_link_t;

    // B element write, broadcast to all cells; the cell owning col takes it
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] data;
    } dmm_bwr_t;

endpackage

`default_nettype wire

// File: sv/dense_matrix_multiply.sv
`default_nettype none

// Square integer matrix product C = A x B of size DIM. Load items write one
// element of A (op 0) or B (op 1); writes out of range are dropped. A
// compute item (op 2) streams row i of A through a chain of DIM cells, cell j
// holding column j of B and forming one 32-bit wrapping dot product; the DIM
// results then shift out of cell 0 in column order, last set on the final
// column. A compute item occupies the block while it feeds the row, waits for
// the wavefront to reach the last cell, and drains the DIM results, plus any
// output stall. No input is taken during that time. Compute on a row of DIM
// or beyond and op 3 give nothing.
module dense_matrix_multiply
    import dmm_pkg::*;
#(
    parameter int DIM = DIM_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               op,
    input  wire logic [IDX_W-1:0]         row,
    input  wire logic [IDX_W-1:0]         col,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic      [IDX_W-1:0]         out_row,
    output logic      [IDX_W-1:0]         out_col,
    output logic signed [DATA_W-1:0]      sum,
    output logic                          last
);

    localparam int KW  = $clog2(DIM);
    localparam int AAW = $clog2(DIM * DIM);
    localparam logic [AAW-1:0] DIM_A  = AAW'(DIM);
    localparam logic [KW-1:0]  K_LAST = KW'(DIM - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FEED  = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [AAW-1:0]    base_reg, base_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [KW-1:0]     cnt_reg, cnt_next;
    logic              feed_vld_reg, feed_vld_next;
    logic              feed_first_reg, feed_first_next;
    logic              feed_last_reg, feed_last_next;

    logic              in_xfer;
    logic              out_xfer;
    logic              idx_ok;
    logic              a_we;
    logic [AAW-1:0]    a_waddr;
    logic [AAW-1:0]    a_raddr;
    logic [DATA_W-1:0] a_rdata;
    dmm_bwr_t          bwr;

    dmm_link_t         link [DIM+1];
    logic [DATA_W-1:0] res [DIM+1];
    logic [DIM-1:0]    done_vec;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DRAIN);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    assign idx_ok  = (32'(row) < DIM) && (32'(col) < DIM);
    assign a_we    = in_xfer && (op == OP_WR_A) && idx_ok;
    assign a_waddr = AAW'(row) * DIM_A + AAW'(col);
    assign a_raddr = base_reg + AAW'(k_reg);

    assign bwr.we   = in_xfer && (op == OP_WR_B) && idx_ok;
    assign bwr.row  = row;
    assign bwr.col  = col;
    assign bwr.data = value;

    dmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DIM * DIM)
    ) u_astore (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // read data of A arrives together with the registered feed flags
    assign link[0].vld   = feed_vld_reg;
    assign link[0].first = feed_first_reg;
    assign link[0].last  = feed_last_reg;
    assign link[0].a     = a_rdata;
    assign res[DIM]      = '0;

    for (genvar j = 0; j < DIM; j++)
    begin : g_cell
        dmm_cell #(
            .DIM (DIM),
            .IDX (j)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .link_i (link[j]),
            .bwr    (bwr),
            .shift  (out_xfer),
            .res_in (res[j+1]),
            .link_o (link[j+1]),
            .res    (res[j]),
            .done   (done_vec[j])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        base_next       = base_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        cnt_next        = cnt_reg;
        feed_vld_next   = 1'b0;
        feed_first_next = 1'b0;
        feed_last_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (op == OP_ROW) && (32'(row) < DIM))
                begin
                    row_next   = row;
                    base_next  = AAW'(row) * DIM_A;
                    k_next     = '0;
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                feed_vld_next   = 1'b1;
                feed_first_next = (k_reg == '0);
                feed_last_next  = (k_reg == K_LAST);
                k_next          = k_reg + KW'(1);
                if (k_reg == K_LAST)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // the last cell finishes after all others
                if (done_vec[DIM-1])
                begin
                    cnt_next   = '0;
                    col_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_xfer)
                begin
                    cnt_next = cnt_reg + KW'(1);
                    col_next = col_reg + IDX_W'(1);
                    if (cnt_reg == K_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            feed_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            feed_vld_reg <= feed_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        base_reg       <= base_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        cnt_reg        <= cnt_next;
        feed_first_reg <= feed_first_next;
        feed_last_reg  <= feed_last_next;
    end

    assign out_row = row_reg;
    assign out_col = col_reg;
    assign sum     = $signed(res[0]);
    assign last    = (cnt_reg == K_LAST);

endmodule

`default_nettype wire

// File: sv/dmm_ram.sv
`default_nettype none

module dmm_ram
    import dmm_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = DIM_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/dmm_cell.sv
`default_nettype none

module dmm_cell
    import dmm_pkg::*;
#(
    parameter int DIM = DIM_DEF,
    parameter int IDX = 0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dmm_link_t         link_i,
    input  wire dmm_bwr_t          bwr,
    input  wire logic              shift,
    input  wire logic [DATA_W-1:0] res_in,
    output dmm_link_t              link_o,
    output logic      [DATA_W-1:0] res,
    output logic                   done
);

    localparam int AW = $clog2(DIM);

    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     cnt_reg;
    logic [AW-1:0]     cnt_next;
    logic              b_we;
    logic [DATA_W-1:0] b_rdata;

    dmm_link_t         link_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] prod_next;
    logic              pvld_reg;
    logic              pfirst_reg;
    logic              plast_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] acc_next;
    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] res_next;
    logic              done_reg;
    logic              done_next;

    // this cell holds column IDX of B, addressed by its own local index k
    assign b_we = bwr.we && (32'(bwr.col) == IDX);

    dmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DIM)
    ) u_bcol (
        .clk   (clk),
        .we    (b_we),
        .waddr (AW'(bwr.row)),
        .wdata (bwr.data),
        .raddr (rd_addr),
        .rdata (b_rdata)
    );

    // k follows the order of the elements flowing past
    assign rd_addr  = link_i.first ? '0 : cnt_reg;
    assign cnt_next = link_i.vld ? rd_addr + AW'(1) : cnt_reg;

    // low 32 bits of the product are all the wrapping sum needs
    assign prod_next = DATA_W'(link_reg.a * b_rdata);
    assign acc_next  = pfirst_reg ? prod_reg : acc_reg + prod_reg;
    assign done_next = pvld_reg && plast_reg;

    always_comb
    begin
        res_next = res_reg;
        if (done_next)
        begin
            res_next = acc_next;
        end
        else if (shift)
        begin
            res_next = res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
            pvld_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            link_reg <= link_i;
            pvld_reg <= link_reg.vld;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        pfirst_reg <= link_reg.first;
        plast_reg  <= link_reg.last;
        if (pvld_reg)
        begin
            acc_reg <= acc_next;
        end
        res_reg <= res_next;
    end

    assign link_o = link_reg;
    assign res    = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire
